// ----- rtl/core/gsrd_pkg.sv -----
`timescale 1ns / 1ps

package gsrd_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_U    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_V    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_RATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL_RATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd6;

    localparam logic [15:0] RST_GRID_ROWS = 16'd256;
    localparam logic [10:0] RST_GRID_COLS = 11'd256;
    localparam logic [15:0] RST_DIFF_U    = 16'd10486;
    localparam logic [15:0] RST_DIFF_V    = 16'd5243;
    localparam logic [15:0] RST_FEED_RATE = 16'd2294;
    localparam logic [15:0] RST_KILL_RATE = 16'd4260;
    localparam logic [15:0] RST_TIME_STEP = 16'd4096;

    // Smallest grid the stencil can work on.
    localparam int MIN_DIM = 3;

    // Item operation codes.
    localparam logic OP_FLUSH = 1'b1;

    // Fixed-point scaling of the update.
    localparam int LAP_DIV    = 20;
    localparam int COEF_SHIFT = 16;
    localparam int DT_SHIFT   = 12;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0] diff_u;
        logic [15:0] diff_v;
        logic [15:0] feed_rate;
        logic [15:0] kill_rate;
        logic [15:0] time_step;
    } t_coef;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SHIFT,
        F_LAP
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LAPU,
        B_LAPV,
        B_UV,
        B_UVV,
        B_FEED,
        B_KILL,
        B_KCAP,
        B_WAIT,
        B_SUM,
        B_TU,
        B_TV,
        B_TCAP,
        B_OUT
    } t_back_state;

endpackage

// ----- rtl/core/gsrd_front.sv -----
`timescale 1ns / 1ps

module gsrd_front #(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 16,
    parameter int CW         = $clog2(MAX_COLS + 1),
    parameter int JW         = 4 * VALUE_BITS + 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [VALUE_BITS-1:0] i_u_in,
    input  logic [VALUE_BITS-1:0] i_v_in,
    input  logic [15:0]           i_rows,
    input  logic [CW-1:0]         i_cols,
    output logic                  o_push,
    output logic [JW-1:0]         o_job,
    input  logic                  i_q_full
);
    import gsrd_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int LW    = VB + 6;
    localparam int IW    = $clog2(MAX_COLS);
    localparam int MW    = $clog2(2 * MAX_COLS);
    localparam int DEPTH = 2 * MAX_COLS;

    t_front_state r_state, n_state;

    logic [15:0]   r_in_row, r_out_row;
    logic [IW-1:0] r_in_col, r_out_col;
    logic          r_emit;
    logic [MW-1:0] r_pa;

    logic signed [VB-1:0] r_u_new, r_v_new;
    logic signed [VB-1:0] r_u_top, r_u_mid, r_v_top, r_v_mid;
    logic signed [VB-1:0] r_u_mem [DEPTH];
    logic signed [VB-1:0] r_v_mem [DEPTH];
    logic signed [VB-1:0] r_uw [9];
    logic signed [VB-1:0] r_vw [9];

    logic          take, flush, draining;
    logic [MW-1:0] pa, qa;
    logic [CW-1:0] in_col_inc, out_col_inc;
    logic [16:0]   out_row_inc;
    logic          inner, last;
    logic signed [LW-1:0] lap_u, lap_v;

    function automatic logic signed [LW-1:0] lap20(input logic signed [VB-1:0] w [9]);
        logic signed [LW-1:0] c, e, m;
        c = LW'(w[0]) + LW'(w[2]) + LW'(w[6]) + LW'(w[8]);
        e = LW'(w[1]) + LW'(w[3]) + LW'(w[5]) + LW'(w[7]);
        m = LW'(w[4]);
        return c + (e <<< 2) - (m <<< 4) - (m <<< 2);
    endfunction

    always_comb begin
        flush    = (i_operation == OP_FLUSH);
        draining = (r_in_row >= i_rows);
        take     = (r_state == F_IDLE) && i_in_valid
                   && !(flush && r_in_row == 16'd0 && r_in_col == '0);
        pa = r_in_row[0] ? MW'(MAX_COLS) + MW'(r_in_col) : MW'(r_in_col);
        qa = r_in_row[0] ? MW'(r_in_col) : MW'(MAX_COLS) + MW'(r_in_col);
        in_col_inc  = CW'(r_in_col) + CW'(1);
        out_col_inc = CW'(r_out_col) + CW'(1);
        out_row_inc = {1'b0, r_out_row} + 17'd1;
        inner = (r_out_row != 16'd0) && (out_row_inc < {1'b0, i_rows})
                && (r_out_col != '0) && (out_col_inc < i_cols);
        last  = (out_row_inc >= {1'b0, i_rows}) && (out_col_inc >= i_cols);
        lap_u = inner ? lap20(r_uw) : '0;
        lap_v = inner ? lap20(r_vw) : '0;
        o_push = (r_state == F_LAP) && !i_q_full;
        o_job  = {last, lap_v, lap_u, r_vw[4], r_uw[4]};
        o_in_stall = (r_state != F_IDLE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (take) n_state = F_SHIFT;
            F_SHIFT: n_state = r_emit ? F_LAP : F_IDLE;
            F_LAP:   if (o_push) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Raster counters on both sides of the stencil delay.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_emit    <= 1'b0;
        end else if (take) begin
            r_emit <= (r_in_row >= 16'd2) || (r_in_row == 16'd1 && r_in_col != '0);
            if (in_col_inc >= i_cols) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + 16'd1;
            end else begin
                r_in_col <= in_col_inc[IW-1:0];
            end
        end else if (o_push) begin
            if (last) begin
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else if (out_col_inc >= i_cols) begin
                r_out_col <= '0;
                r_out_row <= out_row_inc[15:0];
            end else begin
                r_out_col <= out_col_inc[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_u_new <= (flush || draining) ? '0 : $signed(i_u_in);
            r_v_new <= (flush || draining) ? '0 : $signed(i_v_in);
            r_pa    <= pa;
            r_u_top <= r_u_mem[pa];
            r_u_mid <= r_u_mem[qa];
            r_v_top <= r_v_mem[pa];
            r_v_mid <= r_v_mem[qa];
        end
        if (r_state == F_SHIFT) begin
            r_u_mem[r_pa] <= r_u_new;
            r_v_mem[r_pa] <= r_v_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_uw[i] <= '0;
                r_vw[i] <= '0;
            end
        end else if (r_state == F_SHIFT) begin
            for (int r = 0; r < 3; r++) begin
                r_uw[r*3]   <= r_uw[r*3+1];
                r_uw[r*3+1] <= r_uw[r*3+2];
                r_vw[r*3]   <= r_vw[r*3+1];
                r_vw[r*3+1] <= r_vw[r*3+2];
            end
            r_uw[2] <= r_u_top;
            r_uw[5] <= r_u_mid;
            r_uw[8] <= r_u_new;
            r_vw[2] <= r_v_top;
            r_vw[5] <= r_v_mid;
            r_vw[8] <= r_v_new;
        end
    end

endmodule

// ----- rtl/core/gsrd_queue.sv -----
`timescale 1ns / 1ps

module gsrd_queue #(
    parameter int WIDTH = 77
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import gsrd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [NW-1:0]    r_cnt;

    assign o_full  = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + NW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ----- rtl/core/gsrd_div.sv -----
`timescale 1ns / 1ps

module gsrd_div #(
    parameter int VALUE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [VALUE_BITS+5:0]  i_num_u,
    input  logic signed [VALUE_BITS+5:0]  i_num_v,
    output logic                          o_busy,
    output logic signed [VALUE_BITS+7:0]  o_quo_u,
    output logic signed [VALUE_BITS+7:0]  o_quo_v
);
    import gsrd_pkg::*;

    localparam int NW = VALUE_BITS + 6;
    localparam int AW = VALUE_BITS + 8;
    localparam int KS = NW + 4;
    localparam int QW = NW - 4;
    localparam int PW = 2 * NW;

    // Twenty's reciprocal scaled by 2^KS and rounded up. The excess is small enough that
    // the truncated product is the exact quotient for every magnitude below 2^NW.
    localparam logic [NW-1:0] RECIP =
        NW'(((64'd1 << KS) + 64'(LAP_DIV - 1)) / 64'(LAP_DIV));

    // Two lanes: the magnitudes load in the start cycle and are multiplied in the next.
    logic [NW-1:0] r_n   [2];
    logic          r_neg [2];
    logic [QW-1:0] r_quo [2];
    logic          r_busy;

    logic signed [NW-1:0] num  [2];
    logic [PW-1:0]        prod [2];
    logic signed [AW-1:0] q    [2];

    assign num[0] = i_num_u;
    assign num[1] = i_num_v;
    assign o_busy = r_busy;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            prod[l] = PW'(r_n[l]) * PW'(RECIP);
            q[l]    = $signed({6'b000000, r_quo[l]});
            if (r_neg[l]) q[l] = -q[l];
        end
    end

    assign o_quo_u = q[0];
    assign o_quo_v = q[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (i_start) begin
                // A negative dividend is rounded towards minus infinity.
                r_neg[l] <= num[l][NW-1];
                r_n[l]   <= num[l][NW-1] ? (NW'(0) - NW'(num[l]) + NW'(LAP_DIV - 1))
                                         : NW'(num[l]);
            end else if (r_busy) begin
                r_quo[l] <= prod[l][PW-1:KS];
            end
        end
    end

endmodule

// ----- rtl/core/gsrd_back.sv -----
`timescale 1ns / 1ps

module gsrd_back #(
    parameter int VALUE_BITS = 16,
    parameter int JW         = 4 * VALUE_BITS + 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  logic [JW-1:0]                 i_job,
    input  gsrd_pkg::t_coef               i_coef,
    output logic                          o_div_start,
    output logic signed [VALUE_BITS+5:0]  o_div_num_u,
    output logic signed [VALUE_BITS+5:0]  o_div_num_v,
    input  logic                          i_div_busy,
    input  logic signed [VALUE_BITS+7:0]  i_quo_u,
    input  logic signed [VALUE_BITS+7:0]  i_quo_v,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [VALUE_BITS-1:0]         o_u_out,
    output logic [VALUE_BITS-1:0]         o_v_out,
    output logic                          o_last_cell,
    output logic                          o_clipped
);
    import gsrd_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int FB = VB - 2;
    localparam int LW = VB + 6;
    localparam int NW = VB + 6;
    localparam int AW = VB + 8;
    localparam int BW = (VB > 18) ? VB : 18;
    localparam int PW = AW + BW;

    localparam logic signed [AW-1:0] ONE    = AW'(1) <<< FB;
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (VB - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    t_back_state r_state, n_state;

    logic signed [VB-1:0] r_cu, r_cv;
    logic signed [LW-1:0] r_lapu, r_lapv;
    logic                 r_last;
    logic signed [NW-1:0] r_num_u;
    logic signed [AW-1:0] r_uvv, r_feed, r_kill, r_du, r_dv, r_nu, r_nv;
    logic signed [PW-1:0] r_prod;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] sh_f, sh_c, sh_t;
    logic                 load_out;

    logic                 r_out_valid, r_last_cell, r_clipped;
    logic [VB-1:0]        r_u_out, r_v_out;

    function automatic logic signed [VB-1:0] sat(input logic signed [AW-1:0] x);
        if (x > SAT_HI) return VB'(SAT_HI);
        if (x < SAT_LO) return VB'(SAT_LO);
        return VB'(x);
    endfunction

    assign sh_f = r_prod >>> FB;
    assign sh_c = r_prod >>> COEF_SHIFT;
    assign sh_t = r_prod >>> DT_SHIFT;

    // One shared multiplier; each multiplying state queues one product for the next.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            B_LAPU: begin
                mul_a = AW'(r_lapu);
                mul_b = $signed({{(BW-16){1'b0}}, i_coef.diff_u});
            end
            B_LAPV: begin
                mul_a = AW'(r_lapv);
                mul_b = $signed({{(BW-16){1'b0}}, i_coef.diff_v});
            end
            B_UV: begin
                mul_a = AW'(r_cu);
                mul_b = BW'(r_cv);
            end
            B_UVV: begin
                mul_a = sh_f[AW-1:0];
                mul_b = BW'(r_cv);
            end
            B_FEED: begin
                mul_a = ONE - AW'(r_cu);
                mul_b = $signed({{(BW-16){1'b0}}, i_coef.feed_rate});
            end
            B_KILL: begin
                mul_a = AW'(r_cv);
                mul_b = $signed({{(BW-17){1'b0}},
                                 {1'b0, i_coef.feed_rate} + {1'b0, i_coef.kill_rate}});
            end
            B_TU: begin
                mul_a = r_du;
                mul_b = $signed({{(BW-16){1'b0}}, i_coef.time_step});
            end
            B_TV: begin
                mul_a = r_dv;
                mul_b = $signed({{(BW-16){1'b0}}, i_coef.time_step});
            end
            default: ;
        endcase
    end

    always_comb begin
        o_q_pop     = (r_state == B_IDLE) && i_q_valid;
        o_div_start = (r_state == B_UV);
        o_div_num_u = r_num_u;
        o_div_num_v = sh_c[NW-1:0];
        load_out    = (r_state == B_OUT) && (!r_out_valid || !i_out_stall);
        n_state     = r_state;
        unique case (r_state)
            B_IDLE: if (i_q_valid) n_state = B_LAPU;
            B_LAPU: n_state = B_LAPV;
            B_LAPV: n_state = B_UV;
            B_UV:   n_state = B_UVV;
            B_UVV:  n_state = B_FEED;
            B_FEED: n_state = B_KILL;
            B_KILL: n_state = B_KCAP;
            B_KCAP: n_state = B_WAIT;
            B_WAIT: if (!i_div_busy) n_state = B_SUM;
            B_SUM:  n_state = B_TU;
            B_TU:   n_state = B_TV;
            B_TV:   n_state = B_TCAP;
            B_TCAP: n_state = B_OUT;
            B_OUT:  if (load_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            B_IDLE: begin
                r_cu   <= $signed(i_job[VB-1:0]);
                r_cv   <= $signed(i_job[2*VB-1:VB]);
                r_lapu <= $signed(i_job[2*VB+LW-1:2*VB]);
                r_lapv <= $signed(i_job[2*VB+2*LW-1:2*VB+LW]);
                r_last <= i_job[JW-1];
            end
            B_LAPV: r_num_u <= sh_c[NW-1:0];
            B_FEED: r_uvv   <= sh_f[AW-1:0];
            B_KILL: r_feed  <= sh_c[AW-1:0];
            B_KCAP: r_kill  <= sh_c[AW-1:0];
            B_SUM: begin
                r_du <= i_quo_u - r_uvv + r_feed;
                r_dv <= i_quo_v + r_uvv - r_kill;
            end
            B_TV:   r_nu <= AW'(r_cu) + sh_t[AW-1:0];
            B_TCAP: r_nv <= AW'(r_cv) + sh_t[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_u_out     <= sat(r_nu);
            r_v_out     <= sat(r_nv);
            r_last_cell <= r_last;
            r_clipped   <= (r_nu > SAT_HI) || (r_nu < SAT_LO)
                           || (r_nv > SAT_HI) || (r_nv < SAT_LO);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_u_out     = r_u_out;
    assign o_v_out     = r_v_out;
    assign o_last_cell = r_last_cell;
    assign o_clipped   = r_clipped;

endmodule

// ----- rtl/core/gray_scott_reaction_diffusion_step.sv -----
`timescale 1ns / 1ps

// One Gray-Scott reaction-diffusion step over a grid streamed in raster order, one cell a
// beat. Each result belongs to the cell one row and one column behind the input, so a frame
// ends with flush beats that drain the last results; a flush at the very start of a frame
// is dropped. The front end handles one beat at a time and stalls the input meanwhile,
// reading both line stores at two addresses and shifting the 3x3 windows. The back end
// works through each result with a single shared multiplier that walks through the
// products one after another, and the divide by twenty of the two Laplacian terms is a
// reciprocal multiplication that finishes while those products are still being formed;
// the front end can go on taking beats while the back end works, until the queue is full.
// A two-entry queue sits between the two halves. Configuration is written through its own
// port, which is always ready, and should only be changed while the block is idle.
module gray_scott_reaction_diffusion_step #(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic [VALUE_BITS-1:0]           i_u_in,
    input  logic [VALUE_BITS-1:0]           i_v_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [VALUE_BITS-1:0]           o_u_out,
    output logic [VALUE_BITS-1:0]           o_v_out,
    output logic                            o_last_cell,
    output logic                            o_clipped,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gsrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsrd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gsrd_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int JW = 4 * VB + 13;

    // Configuration registers, taken as written and clamped on use.
    logic [15:0] r_grid_rows;
    logic [10:0] r_grid_cols;
    t_coef       r_coef;

    logic [15:0] rows;
    logic [CW-1:0] cols;
    logic [31:0] cols_w;

    logic          q_push, q_full, q_pop, q_valid;
    logic [JW-1:0] job_in, job_out;

    logic                 div_start, div_busy;
    logic signed [VB+5:0] div_num_u, div_num_v;
    logic signed [VB+7:0] quo_u, quo_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows      <= RST_GRID_ROWS;
            r_grid_cols      <= RST_GRID_COLS;
            r_coef.diff_u    <= RST_DIFF_U;
            r_coef.diff_v    <= RST_DIFF_V;
            r_coef.feed_rate <= RST_FEED_RATE;
            r_coef.kill_rate <= RST_KILL_RATE;
            r_coef.time_step <= RST_TIME_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_ROWS: r_grid_rows      <= i_cfg_data;
                CFG_GRID_COLS: r_grid_cols      <= i_cfg_data[10:0];
                CFG_DIFF_U:    r_coef.diff_u    <= i_cfg_data;
                CFG_DIFF_V:    r_coef.diff_v    <= i_cfg_data;
                CFG_FEED_RATE: r_coef.feed_rate <= i_cfg_data;
                CFG_KILL_RATE: r_coef.kill_rate <= i_cfg_data;
                CFG_TIME_STEP: r_coef.time_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A dimension smaller than the stencil is raised to three, and the column count
    // never exceeds the line store.
    always_comb begin
        rows   = (r_grid_rows < 16'(MIN_DIM)) ? 16'(MIN_DIM) : r_grid_rows;
        cols_w = 32'(r_grid_cols);
        if (cols_w < 32'(MIN_DIM))       cols_w = 32'(MIN_DIM);
        else if (cols_w > 32'(MAX_COLS)) cols_w = 32'(MAX_COLS);
        cols = CW'(cols_w);
    end

    gsrd_front #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VB),
        .CW         (CW),
        .JW         (JW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_u_in      (i_u_in),
        .i_v_in      (i_v_in),
        .i_rows      (rows),
        .i_cols      (cols),
        .o_push      (q_push),
        .o_job       (job_in),
        .i_q_full    (q_full)
    );

    gsrd_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (job_out)
    );

    gsrd_div #(
        .VALUE_BITS (VB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_u (div_num_u),
        .i_num_v (div_num_v),
        .o_busy  (div_busy),
        .o_quo_u (quo_u),
        .o_quo_v (quo_v)
    );

    gsrd_back #(
        .VALUE_BITS (VB),
        .JW         (JW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_job       (job_out),
        .i_coef      (r_coef),
        .o_div_start (div_start),
        .o_div_num_u (div_num_u),
        .o_div_num_v (div_num_v),
        .i_div_busy  (div_busy),
        .i_quo_u     (quo_u),
        .i_quo_v     (quo_v),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_u_out     (o_u_out),
        .o_v_out     (o_v_out),
        .o_last_cell (o_last_cell),
        .o_clipped   (o_clipped)
    );

    // The front end must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("job pushed into a full queue");

    // The divider is only restarted once the previous division has finished.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_start && div_busy))
        else $error("divider restarted while busy");

    // A clipped result carries at least one value at a rail of the output range.
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_u_out == {1'b0, {(VB-1){1'b1}}}) || (o_u_out == {1'b1, {(VB-1){1'b0}}})
            || (o_v_out == {1'b0, {(VB-1){1'b1}}}) || (o_v_out == {1'b1, {(VB-1){1'b0}}}))
        else $error("clipped flag without a saturated value");

endmodule
